FILE: sv/kimr_pkg.sv
// Shared types and constants for the knot insertion matrix row generator.
`timescale 1ns / 1ps
`default_nettype none
package kimr_pkg;

   localparam int FRAC_BITS     = 16;
   localparam int KNOT_W        = 32;
   localparam int WEIGHT_W      = FRAC_BITS + 1;
   localparam int DIFF_W        = KNOT_W + 1;
   localparam int DVD_W         = DIFF_W + FRAC_BITS;
   localparam int RATIO_LOG     = 40;
   localparam int MAG_W         = RATIO_LOG + 1;
   localparam int PROD_W        = MAG_W + WEIGHT_W;
   localparam int TERM_W        = MAG_W + 1;
   localparam int SUM_W         = TERM_W + 1;
   localparam int CNT_W         = $clog2(DVD_W);
   localparam int COLUMN_W      = 5;
   localparam int INDEX_W       = 5;

   localparam int DEF_MAX_OLD_KNOTS = 32;
   localparam int DEF_MAX_DEGREE    = 5;

   localparam logic [2:0] DEGREE_RESET = 3'd3;
   localparam logic [5:0] COUNT_RESET  = 6'd8;

   localparam logic [WEIGHT_W-1:0] ONE_W = WEIGHT_W'(1) << FRAC_BITS;

   localparam logic REQ_OLD_KNOT = 1'b0;
   localparam logic REQ_REFINED  = 1'b1;

   typedef enum logic [0:0] {
      CSR_DEGREE = 1'b0,
      CSR_COUNT  = 1'b1
   } csr_addr_type;

   typedef struct packed {
      logic                     start;
      logic signed [DIFF_W-1:0] num;
      logic signed [DIFF_W-1:0] den;
      logic [WEIGHT_W-1:0]      w;
   } term_cmd_type;

   typedef struct packed {
      logic                     done;
      logic signed [TERM_W-1:0] value;
   } term_rsp_type;

endpackage
`default_nettype wire

FILE: sv/kimr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module kimr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/kimr_term.sv
// Serial ratio-times-weight unit: restoring divider followed by shift-add multiplier.
`timescale 1ns / 1ps
`default_nettype none
module kimr_term import kimr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire term_cmd_type cmd,
   output term_rsp_type      rsp
);

   typedef enum logic [2:0] {
      T_IDLE = 3'b001,
      T_DIV  = 3'b010,
      T_MUL  = 3'b100
   } term_state_type;

   localparam logic [DVD_W-1:0] RATIO_LIM = DVD_W'(1) << RATIO_LOG;

   term_state_type      state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                done_ff, done_in;
   logic                neg_ff, neg_in;
   logic [DIFF_W-1:0]   den_ff, den_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [DIFF_W-1:0]   rem_ff, rem_in;
   logic [PROD_W-1:0]   mcand_ff, mcand_in;
   logic [WEIGHT_W-1:0] mplier_ff, mplier_in;
   logic [PROD_W-1:0]   acc_ff, acc_in;

   logic [DIFF_W-1:0]   num_mag;
   logic [DIFF_W-1:0]   den_mag;
   logic [DIFF_W:0]     trial;
   logic [DIFF_W:0]     trial_sub;
   logic                fits;
   logic [DVD_W-1:0]    quotient;
   logic [MAG_W-1:0]    mag;

   always_comb begin
      num_mag   = cmd.num[DIFF_W-1] ? DIFF_W'(-cmd.num) : DIFF_W'(cmd.num);
      den_mag   = cmd.den[DIFF_W-1] ? DIFF_W'(-cmd.den) : DIFF_W'(cmd.den);
      trial     = {rem_ff, dvd_ff[DVD_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});
      quotient  = {dvd_ff[DVD_W-2:0], fits};

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      neg_in    = neg_ff;
      den_in    = den_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;

      unique case (state_ff)
         T_IDLE: begin
            if (cmd.start) begin
               neg_in    = cmd.num[DIFF_W-1] ^ cmd.den[DIFF_W-1];
               den_in    = den_mag;
               dvd_in    = {num_mag, FRAC_BITS'(0)};
               rem_in    = '0;
               mplier_in = cmd.w;
               acc_in    = '0;
               cnt_in    = CNT_W'(DVD_W - 1);
               state_in  = T_DIV;
            end
         end
         T_DIV: begin
            rem_in = fits ? trial_sub[DIFF_W-1:0] : trial[DIFF_W-1:0];
            dvd_in = quotient;
            if (cnt_ff == '0) begin
               // The ratio saturates before it scales the weight.
               mcand_in = (quotient > RATIO_LIM) ? PROD_W'(RATIO_LIM) : PROD_W'(quotient);
               cnt_in   = CNT_W'(WEIGHT_W - 1);
               state_in = T_MUL;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         T_MUL: begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff << 1;
            mplier_in = mplier_ff >> 1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = T_IDLE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      neg_ff    <= neg_in;
      den_ff    <= den_in;
      dvd_ff    <= dvd_in;
      rem_ff    <= rem_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign mag       = acc_ff[FRAC_BITS +: MAG_W];
   assign rsp.done  = done_ff;
   assign rsp.value = neg_ff ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule
`default_nettype wire

FILE: sv/knot_insertion_matrix_rows.sv
// Oslo knot insertion matrix rows: one weight per old-basis column for each refined knot.
// Old knot writes, the final refined knot and a push without a row leave the block idle.
// A row first builds the span indicator, then for each column and level runs up to
// two serial divisions of 49 steps and multiplications of 17 steps in the shared
// term unit, then emits one column at a time, each held until the output accepts it.
// Reset is synchronous: window, fill count and control clear, degree 3, old knot count 8.
`timescale 1ns / 1ps
`default_nettype none
module knot_insertion_matrix_rows import kimr_pkg::*; #(
   parameter int MAX_OLD_KNOTS = DEF_MAX_OLD_KNOTS,
   parameter int MAX_DEGREE    = DEF_MAX_DEGREE
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // knot_index[4:0], knot_value[36:5], zero fill
   input  wire logic        req_tuser,   // req_type
   input  wire logic        req_tlast,   // final_refined
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // column[4:0], weight[21:5], zero fill
   output logic             rsp_tlast,   // last_in_row
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [5:0]  csr_data
);

   localparam int WIN_D = MAX_DEGREE + 1;
   localparam int WW    = $clog2(WIN_D);
   localparam int FW    = $clog2(WIN_D + 1);
   localparam int KA_W  = $clog2(MAX_OLD_KNOTS);
   localparam int RW_D  = MAX_OLD_KNOTS - 1;
   localparam int RA_W  = (RW_D > 1) ? $clog2(RW_D) : 1;
   localparam int CW    = $clog2(MAX_OLD_KNOTS + 1);

   typedef enum logic [16:0] {
      S_IDLE     = 17'b00000000000000001,
      S_INIT_A   = 17'b00000000000000010,
      S_INIT_B   = 17'b00000000000000100,
      S_INIT_W   = 17'b00000000000001000,
      S_COL_0    = 17'b00000000000010000,
      S_COL_1    = 17'b00000000000100000,
      S_COL_2    = 17'b00000000001000000,
      S_COL_3    = 17'b00000000010000000,
      S_COL_4    = 17'b00000000100000000,
      S_T1_GO    = 17'b00000001000000000,
      S_T1_WAIT  = 17'b00000010000000000,
      S_T2_GO    = 17'b00000100000000000,
      S_T2_WAIT  = 17'b00001000000000000,
      S_COL_WR   = 17'b00010000000000000,
      S_OUT_RD   = 17'b00100000000000000,
      S_OUT_LD   = 17'b01000000000000000,
      S_OUT_WAIT = 17'b10000000000000000
   } state_type;

   state_type                state_ff, state_in;
   logic [2:0]               degree_ff, degree_in;
   logic [5:0]               count_ff, count_in;
   logic signed [KNOT_W-1:0] win_ff [WIN_D];
   logic signed [KNOT_W-1:0] win_in [WIN_D];
   logic [FW-1:0]            fill_ff, fill_in;
   logic [WW-1:0]            base_ff, base_in;
   logic [WW-1:0]            q_ff, q_in;
   logic [CW-1:0]            j_ff, j_in;
   logic signed [KNOT_W-1:0] ka_ff, ka_in;
   logic signed [KNOT_W-1:0] kq_ff, kq_in;
   logic signed [KNOT_W-1:0] k1_ff, k1_in;
   logic signed [KNOT_W-1:0] kq1_ff, kq1_in;
   logic [WEIGHT_W-1:0]      w0_ff, w0_in;
   logic [WEIGHT_W-1:0]      w1_ff, w1_in;
   logic signed [SUM_W-1:0]  s_ff, s_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [COLUMN_W-1:0]      rsp_col_ff, rsp_col_in;
   logic [WEIGHT_W-1:0]      rsp_w_ff, rsp_w_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic [WW-1:0]            p_eff;
   logic [CW-1:0]            n_eff;
   logic                     req_fire;
   logic [INDEX_W-1:0]       req_index;
   logic signed [KNOT_W-1:0] req_value;
   logic signed [KNOT_W-1:0] x_cur;
   logic signed [KNOT_W-1:0] x_zero;
   logic                     kn_we;
   logic [KA_W-1:0]          kn_waddr;
   logic [KA_W-1:0]          kn_raddr;
   logic [KNOT_W-1:0]        kn_rdata;
   logic signed [KNOT_W-1:0] kn_val;
   logic                     rw_we;
   logic [RA_W-1:0]          rw_waddr;
   logic [WEIGHT_W-1:0]      rw_wdata;
   logic [RA_W-1:0]          rw_raddr;
   logic [WEIGHT_W-1:0]      rw_rdata;
   logic signed [DIFF_W-1:0] d1;
   logic signed [DIFF_W-1:0] d2;
   term_cmd_type             term_cmd;
   term_rsp_type             term_rsp;
   logic [CW-1:0]            j_plus1;
   logic [CW-1:0]            j_plusq;
   logic [CW-1:0]            j_plusq1;
   logic signed [SUM_W-1:0]  s_next;
   logic [WEIGHT_W-1:0]      s_clamped;
   int                       fill_new;

   assign req_fire  = req_tvalid && req_tready;
   assign req_index = req_tdata[4:0];
   assign req_value = $signed(req_tdata[36:5]);
   assign kn_val    = $signed(kn_rdata);
   assign p_eff     = (int'(degree_ff) > MAX_DEGREE) ? WW'(MAX_DEGREE) : WW'(degree_ff);
   assign n_eff     = (int'(count_ff) > MAX_OLD_KNOTS) ? CW'(MAX_OLD_KNOTS) : CW'(count_ff);
   assign x_zero    = win_ff[base_ff];
   assign x_cur     = win_ff[WW'(base_ff + q_ff)];
   assign j_plus1   = j_ff + 1'b1;
   assign j_plusq   = j_ff + CW'(q_ff);
   assign j_plusq1  = j_ff + CW'(q_ff) + 1'b1;
   assign d1        = DIFF_W'(kq_ff) - DIFF_W'(ka_ff);
   assign d2        = DIFF_W'(kq1_ff) - DIFF_W'(k1_ff);
   assign s_next    = s_ff + SUM_W'(term_rsp.value);
   assign s_clamped = (s_ff < 0) ? '0 :
                      (s_ff > $signed(SUM_W'(ONE_W))) ? ONE_W : s_ff[WEIGHT_W-1:0];

   always_comb begin
      degree_in = degree_ff;
      count_in  = count_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DEGREE: degree_in = csr_data[2:0];
            CSR_COUNT:  count_in  = csr_data;
            default:    ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      fill_in      = fill_ff;
      base_in      = base_ff;
      q_in         = q_ff;
      j_in         = j_ff;
      ka_in        = ka_ff;
      kq_in        = kq_ff;
      k1_in        = k1_ff;
      kq1_in       = kq1_ff;
      w0_in        = w0_ff;
      w1_in        = w1_ff;
      s_in         = s_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_w_in     = rsp_w_ff;
      rsp_last_in  = rsp_last_ff;
      kn_we        = 1'b0;
      kn_waddr     = KA_W'(req_index);
      kn_raddr     = j_ff[KA_W-1:0];
      rw_we        = 1'b0;
      rw_waddr     = j_ff[RA_W-1:0];
      rw_wdata     = s_clamped;
      rw_raddr     = j_ff[RA_W-1:0];
      term_cmd     = '0;
      fill_new     = int'(fill_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_tuser == REQ_OLD_KNOT) begin
                  kn_we = (int'(req_index) < MAX_OLD_KNOTS);
               end else if (req_tlast) begin
                  for (int i = 0; i < WIN_D; i++) begin
                     win_in[i] = '0;
                  end
                  fill_in = '0;
               end else begin
                  if (int'(fill_ff) < WIN_D) begin
                     win_in[fill_ff[WW-1:0]] = req_value;
                     fill_in  = fill_ff + 1'b1;
                     fill_new = int'(fill_ff) + 1;
                  end else begin
                     for (int i = 0; i < WIN_D - 1; i++) begin
                        win_in[i] = win_ff[i + 1];
                     end
                     win_in[WIN_D-1] = req_value;
                  end
                  base_in = WW'(fill_new - int'(p_eff) - 1);
                  j_in    = '0;
                  if (p_eff != '0 && int'(n_eff) >= int'(p_eff) + 2 &&
                      fill_new >= int'(p_eff) + 1) begin
                     state_in = S_INIT_A;
                  end
               end
            end
         end
         S_INIT_A: begin
            state_in = S_INIT_B;
         end
         S_INIT_B: begin
            kn_raddr = j_plus1[KA_W-1:0];
            ka_in    = kn_val;
            state_in = S_INIT_W;
         end
         S_INIT_W: begin
            // Span indicator: one where the knot at the window base lies in [k[j], k[j+1]).
            rw_we    = 1'b1;
            rw_wdata = (ka_ff <= x_zero && x_zero < kn_val) ? ONE_W : '0;
            if (int'(j_ff) + 2 == int'(n_eff)) begin
               j_in     = '0;
               q_in     = WW'(1);
               state_in = S_COL_0;
            end else begin
               j_in     = j_plus1;
               state_in = S_INIT_A;
            end
         end
         S_COL_0: begin
            state_in = S_COL_1;
         end
         S_COL_1: begin
            kn_raddr = j_plusq[KA_W-1:0];
            ka_in    = kn_val;
            state_in = S_COL_2;
         end
         S_COL_2: begin
            kn_raddr = j_plus1[KA_W-1:0];
            kq_in    = kn_val;
            state_in = S_COL_3;
         end
         S_COL_3: begin
            kn_raddr = j_plusq1[KA_W-1:0];
            rw_raddr = j_plus1[RA_W-1:0];
            k1_in    = kn_val;
            w0_in    = rw_rdata;
            state_in = S_COL_4;
         end
         S_COL_4: begin
            kq1_in   = kn_val;
            w1_in    = rw_rdata;
            state_in = S_T1_GO;
         end
         S_T1_GO: begin
            s_in = '0;
            if (d1 != '0) begin
               term_cmd.start = 1'b1;
               term_cmd.num   = DIFF_W'(x_cur) - DIFF_W'(ka_ff);
               term_cmd.den   = d1;
               term_cmd.w     = w0_ff;
               state_in       = S_T1_WAIT;
            end else begin
               state_in = S_T2_GO;
            end
         end
         S_T1_WAIT: begin
            if (term_rsp.done) begin
               s_in     = s_next;
               state_in = S_T2_GO;
            end
         end
         S_T2_GO: begin
            if (d2 != '0) begin
               term_cmd.start = 1'b1;
               term_cmd.num   = DIFF_W'(kq1_ff) - DIFF_W'(x_cur);
               term_cmd.den   = d2;
               term_cmd.w     = w1_ff;
               state_in       = S_T2_WAIT;
            end else begin
               state_in = S_COL_WR;
            end
         end
         S_T2_WAIT: begin
            if (term_rsp.done) begin
               s_in     = s_next;
               state_in = S_COL_WR;
            end
         end
         S_COL_WR: begin
            // In-place update is safe: the next column reads only entries not yet rewritten.
            rw_we    = 1'b1;
            rw_wdata = s_clamped;
            state_in = S_COL_0;
            if (int'(j_ff) + int'(q_ff) + 2 == int'(n_eff)) begin
               j_in = '0;
               if (q_ff == p_eff) begin
                  state_in = S_OUT_RD;
               end else begin
                  q_in = q_ff + 1'b1;
               end
            end else begin
               j_in = j_plus1;
            end
         end
         S_OUT_RD: begin
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            rsp_valid_in = 1'b1;
            rsp_col_in   = COLUMN_W'(j_ff);
            rsp_w_in     = rw_rdata;
            rsp_last_in  = (int'(j_ff) + int'(p_eff) + 2 == int'(n_eff));
            state_in     = S_OUT_WAIT;
         end
         S_OUT_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               j_in         = j_plus1;
               state_in     = rsp_last_ff ? S_IDLE : S_OUT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         degree_ff    <= DEGREE_RESET;
         count_ff     <= COUNT_RESET;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < WIN_D; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         degree_ff    <= degree_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
         win_ff       <= win_in;
      end
      base_ff     <= base_in;
      q_ff        <= q_in;
      j_ff        <= j_in;
      ka_ff       <= ka_in;
      kq_ff       <= kq_in;
      k1_ff       <= k1_in;
      kq1_ff      <= kq1_in;
      w0_ff       <= w0_in;
      w1_ff       <= w1_in;
      s_ff        <= s_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_w_ff    <= rsp_w_in;
      rsp_last_ff <= rsp_last_in;
   end

   kimr_ram #(
      .WIDTH (KNOT_W),
      .DEPTH (MAX_OLD_KNOTS)
   ) u_knots (
      .clock   (clock),
      .wr_en   (kn_we),
      .wr_addr (kn_waddr),
      .wr_data (req_tdata[36:5]),
      .rd_addr (kn_raddr),
      .rd_data (kn_rdata)
   );

   kimr_ram #(
      .WIDTH (WEIGHT_W),
      .DEPTH (RW_D)
   ) u_row (
      .clock   (clock),
      .wr_en   (rw_we),
      .wr_addr (rw_waddr),
      .wr_data (rw_wdata),
      .rd_addr (rw_raddr),
      .rd_data (rw_rdata)
   );

   kimr_term u_term (
      .clock (clock),
      .reset (reset),
      .cmd   (term_cmd),
      .rsp   (term_rsp)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_w_ff, rsp_col_ff};
   assign rsp_tlast  = rsp_last_ff;

   // Input is taken only once every weight of the previous row has been transferred.
   assert property (@(posedge clock) disable iff (reset) req_tready |-> !rsp_tvalid)
      else $error("input accepted while a result is pending");

   // A delivered weight never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[21:5] <= ONE_W))
      else $error("weight above one");

   // The window never holds more knots than it has slots.
   assert property (@(posedge clock) disable iff (reset) int'(fill_ff) <= WIN_D)
      else $error("window fill overflow");

   // The term unit is started only in the two term-start states of a column step.
   assert property (@(posedge clock) disable iff (reset)
      term_cmd.start |-> (state_ff == S_T1_GO || state_ff == S_T2_GO))
      else $error("term unit started outside a column step");

endmodule
`default_nettype wire

FILE: bench/kimr_checker.sv
// Checker for the knot insertion matrix rows: predicts every row and compares each result transfer.
`timescale 1ns / 1ps
`default_nettype none
module kimr_checker import kimr_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [39:0] req_tdata,
   input  wire logic        req_tuser,
   input  wire logic        req_tlast,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [23:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [0:0]  csr_index,
   input  wire logic [5:0]  csr_data,
   output int               fail_count,
   output int               weights_pending
);
   localparam int  MAX_KNOTS = 32;
   localparam int  MAX_DEG   = 5;
   localparam int  WIN       = MAX_DEG + 1;
   localparam longint ONE    = longint'(1) << FRAC_BITS;
   localparam longint LIM    = longint'(1) << 40;

   typedef struct packed {
      logic [4:0]          column;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } weight_type;

   longint       knot_table [MAX_KNOTS];
   longint       window [WIN];
   int           fill;
   logic [2:0]   degree_reg;
   logic [5:0]   count_reg;
   longint       basis [MAX_KNOTS];
   weight_type   weight_queue [$];

   assign weights_pending = weight_queue.size();

   function automatic longint scaled_term(longint num, longint den, longint w);
      longint r;
      r = (num * ONE) / den;
      if (r > LIM) r = LIM;
      if (r < -LIM) r = -LIM;
      return (r * w) / ONE;
   endfunction

   // Builds one matrix row from the newest p+1 window knots and queues its columns.
   task automatic predict_row(int p, int n);
      int     first;
      int     len;
      longint x;
      longint s;
      longint d1;
      longint d2;
      weight_type item;
      first = fill - p - 1;
      x = window[first];
      for (int j = 0; j + 1 < n; j++)
         basis[j] = (knot_table[j] <= x && x < knot_table[j+1]) ? ONE : 0;
      for (int q = 1; q <= p; q++) begin
         len = n - q - 1;
         x = window[first + q];
         for (int j = 0; j < len; j++) begin
            d1 = knot_table[j+q] - knot_table[j];
            d2 = knot_table[j+q+1] - knot_table[j+1];
            s = 0;
            if (d1 != 0) s += scaled_term(x - knot_table[j], d1, basis[j]);
            if (d2 != 0) s += scaled_term(knot_table[j+q+1] - x, d2, basis[j+1]);
            basis[j] = s < 0 ? 0 : (s > ONE ? ONE : s);
         end
      end
      for (int j = 0; j < n - p - 1; j++) begin
         item.column = j[4:0];
         item.weight = basis[j][WEIGHT_W-1:0];
         item.last   = (j + 1 == n - p - 1);
         weight_queue.insert(weight_queue.size(), item);
      end
   endtask

   task automatic take_knot(logic kind, logic [4:0] idx, logic signed [31:0] val, logic fin);
      int p;
      int n;
      if (kind == REQ_OLD_KNOT) begin
         knot_table[idx] = longint'(val);
      end else if (fin) begin
         for (int i = 0; i < WIN; i++) window[i] = 0;
         fill = 0;
      end else begin
         if (fill < WIN) begin
            window[fill] = longint'(val);
            fill++;
         end else begin
            for (int i = 0; i + 1 < WIN; i++) window[i] = window[i+1];
            window[WIN-1] = longint'(val);
         end
         p = degree_reg > MAX_DEG ? MAX_DEG : int'(degree_reg);
         n = count_reg > MAX_KNOTS ? MAX_KNOTS : int'(count_reg);
         if (p != 0 && n >= p + 2 && fill >= p + 1) predict_row(p, n);
      end
   endtask

   always @(posedge clock) begin
      weight_type want;
      weight_type got;
      if (reset) begin
         for (int i = 0; i < WIN; i++) window[i] = 0;
         fill = 0;
         degree_reg = DEGREE_RESET;
         count_reg = COUNT_RESET;
         weight_queue.delete();
         fail_count <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DEGREE) degree_reg = csr_data[2:0];
            else count_reg = csr_data;
         end
         if (req_tvalid && req_tready)
            take_knot(req_tuser, req_tdata[4:0], req_tdata[36:5], req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[4:0], rsp_tdata[21:5], rsp_tlast};
            if (weight_queue.size() == 0) begin
               $display("%0t: unexpected weight transfer, expected none, actual %h",
                        $time, got);
               fail_count <= fail_count + 1;
            end else begin
               want = weight_queue.pop_front();
               if (want != got) begin
                  $display("%0t: weight mismatch, expected col %0d w %0d last %0b,",
                           $time, want.column, want.weight, want.last);
                  $display("   actual col %0d w %0d last %0b",
                           got.column, got.weight, got.last);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Top of the bench: drives knots and register writes into the row generator and gives the verdict.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import kimr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [5:0]  csr_data = '0;
   int          fail_count;
   int          weights_pending;
   bit          no_gaps = 1'b0;
   longint      old_set [32];

   knot_insertion_matrix_rows i_dut (.*);
   kimr_checker i_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock)
      rsp_tready <= no_gaps || ($urandom_range(99) >= 35);

   // Valid stays high after a transfer until the next item or an idle gap replaces it.
   task automatic send_knot(logic kind, int idx, logic [31:0] val, logic fin);
      if (!no_gaps && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tlast  <= fin;
      req_tdata  <= {3'b000, val, idx[4:0]};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic write_csr(csr_addr_type idx, logic [5:0] val);
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (weights_pending == 0);
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Loads all slots with a nondecreasing set; a step of zero gives a repeated knot.
   task automatic load_knots();
      longint k;
      k = -longint'($urandom_range(1 << 20));
      for (int i = 0; i < 32; i++) begin
         old_set[i] = k;
         send_knot(REQ_OLD_KNOT, i, k[31:0], 1'($urandom_range(1)));
         if ($urandom_range(99) >= 20) k += $urandom_range(1 << 17, 1);
      end
   endtask

   // A refined stream rising from the first old knot, some pushes random, closed by a final knot.
   task automatic refine_run(int n, int pushes);
      longint x;
      longint span;
      span = old_set[n > 32 ? 31 : n - 1] - old_set[0] + 1;
      x = old_set[0];
      for (int i = 0; i < pushes; i++) begin
         if ($urandom_range(9) == 0) send_knot(REQ_REFINED, $urandom_range(31), $urandom, 1'b0);
         else send_knot(REQ_REFINED, $urandom_range(31), x[31:0], 1'b0);
         x += longint'($urandom) % (span / 4 + 1);
      end
      send_knot(REQ_REFINED, $urandom_range(31), $urandom, 1'b1);
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // Directed: extreme knots, a final flag on a write, and an idle final knot.
      send_knot(REQ_OLD_KNOT, 31, 32'h8000_0000, 1'b1);
      send_knot(REQ_OLD_KNOT, 30, 32'h7fff_ffff, 1'b0);
      send_knot(REQ_REFINED, 0, 32'h1234_5678, 1'b1);
      load_knots();
      refine_run(8, 5);
      send_knot(REQ_REFINED, 0, 32'h8000_0000, 1'b0);
      send_knot(REQ_REFINED, 0, 32'h7fff_ffff, 1'b0);
      send_knot(REQ_REFINED, 0, 32'h0000_0000, 1'b0);
      send_knot(REQ_REFINED, 31, 32'hffff_ffff, 1'b0);
      send_knot(REQ_REFINED, 0, 32'h0, 1'b1);
      // Degree five over the full table, sparingly since each row is slow.
      write_csr(CSR_DEGREE, 6'd5);
      write_csr(CSR_COUNT, 6'd32);
      refine_run(32, 7);
      // Too few old knots for degree five, then degree zero and an oversized degree.
      write_csr(CSR_COUNT, 6'd6);
      refine_run(6, 8);
      write_csr(CSR_DEGREE, 6'd0);
      refine_run(6, 4);
      write_csr(CSR_DEGREE, 6'd7);
      write_csr(CSR_COUNT, 6'd9);
      refine_run(9, 10);
      // Random phases, small tables but an oversized count last; gapless stretch in the middle.
      for (int ph = 0; ph < 8; ph++) begin
         int p;
         int n;
         p = $urandom_range(5, 1);
         n = $urandom_range(10, 3);
         if (ph == 3) begin p = 1; n = 3; end
         if (ph == 7) begin p = 1; n = 63; end
         no_gaps = (ph >= 3 && ph <= 5);
         write_csr(CSR_DEGREE, p[5:0]);
         write_csr(CSR_COUNT, n[5:0]);
         if (ph == 2) load_knots();
         refine_run(n, ph == 7 ? 3 : $urandom_range(9, 5));
      end
      no_gaps = 1'b0;
      req_tvalid <= 1'b0;
      @(posedge clock);
      wait (weights_pending == 0);
      repeat (50) @(posedge clock);
      if (fail_count == 0) $display("** knot_insertion_matrix_rows: PASSED **");
      else $display("** knot_insertion_matrix_rows: FAILED **");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("** knot_insertion_matrix_rows: FAILED **");
      $finish;
   end
endmodule
`default_nettype wire

FILE: knot_insertion_matrix_rows.f
sv/kimr_pkg.sv
sv/kimr_ram.sv
sv/kimr_term.sv
sv/knot_insertion_matrix_rows.sv
bench/kimr_checker.sv
bench/testbench.sv
